// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define JSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define JSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define JSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/jss_pkg.sv =====
// Types and constants of the jump search key table.
// No dependencies; used by the top level, controller and datapath.
package jss_pkg;

  localparam int KEY_W   = 32;
  localparam int STEP_W  = 8;
  localparam int INDEX_W = 7;

  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FOUND    = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // read address sources
  localparam logic [1:0] RD_HI_INIT  = 2'd0;
  localparam logic [1:0] RD_HI_ADV   = 2'd1;
  localparam logic [1:0] RD_LO       = 2'd2;
  localparam logic [1:0] RD_IDX_NEXT = 2'd3;

  typedef struct packed {
    logic              op;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] index;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       jump_init;
    logic       jump_adv;
    logic       scan_init;
    logic       scan_adv;
    logic [1:0] rd_sel;
    logic       finish;
    logic [1:0] fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_search;
    logic full;
    logic init_ok;
    logic le;
    logic adv_ok;
    logic lo_ok;
    logic eq;
    logic idx_ok;
  } dp_stat_t;

endpackage

// ===== hw/rtl/jump_search_sorted_keys.sv =====
// Top level of the jump search key table: controller plus datapath.
// Depends on jss_pkg, jss_ctrl, jss_datapath and assert_macros.svh.
//
//  channel  | handshake           | beat
//  ---------+---------------------+------------------------------
//  item     | start & !busy       | op, key
//  result   | done (one cycle)    | status, index
//  step cfg | step_we             | step_data (write when idle)
//
// Append: the result strobe follows the decode state that comes after acceptance.
// Search: decode, jump reads, scan start and scan reads, one key read a cycle through
// the single RAM read port. Synchronous reset clears the count, step register (to 1)
// and controller; the key store is not cleared. The result strobe cannot be stalled.
`include "assert_macros.svh"
module jump_search_sorted_keys
  import jss_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item,
  input  logic              step_we,
  input  logic [STEP_W-1:0] step_data,
  output logic              done,
  output out_item_t         result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  jss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  jss_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .step_we   (step_we),
    .step_data (step_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  `JSS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  `JSS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `JSS_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than a cycle")
  `JSS_ASSERT_SAME(a_full_index, clk, rst,
                   done && (result.status == ST_FULL || result.status == ST_MISSING),
                   result.index == '0, "index not zero for full or missing")

endmodule

// ===== hw/rtl/jss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jss_ram #(
  parameter int W = 32,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/jss_datapath.sv =====
// Datapath: key store, count, step register, jump/scan pointers, result register.
// Depends on jss_pkg and jss_ram.
module jss_datapath
  import jss_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_we,
  input  logic [STEP_W-1:0] step_data,
  input  in_item_t          item,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              done,
  output out_item_t         result
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int HW = $clog2(ENTRIES + 256);

  logic                    op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CW-1:0]           count;
  logic [STEP_W-1:0]       step_r;
  logic [AW-1:0]           lo;
  logic [HW-1:0]           hi;
  logic [AW-1:0]           idx;

  logic [STEP_W-1:0]       step_eff;
  logic [HW-1:0]           hi_init;
  logic [HW-1:0]           hi_adv;
  logic [HW-1:0]           cnt_x;
  logic [HW-1:0]           stop;
  logic [HW-1:0]           idx_next;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] rkey;

  jss_ram #(.W(KEY_W), .D(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (AW'(count)),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
    hi_init  = HW'(step_eff);
    hi_adv   = hi + HW'(step_eff);
    cnt_x    = HW'(count);
    stop     = (hi < cnt_x) ? hi : cnt_x;
    idx_next = HW'(idx) + HW'(1);
    rkey     = $signed(rdata);
    case (cmd.rd_sel)
      RD_HI_INIT:  raddr = AW'(hi_init);
      RD_HI_ADV:   raddr = AW'(hi_adv);
      RD_LO:       raddr = lo;
      RD_IDX_NEXT: raddr = AW'(idx_next);
      default:     raddr = lo;
    endcase
  end

  assign stat.is_search = (op_r == OP_SEARCH);
  assign stat.full      = (count == CW'(ENTRIES));
  assign stat.init_ok   = (hi_init < cnt_x);
  assign stat.le        = (rkey <= key_r);
  assign stat.adv_ok    = (hi_adv < cnt_x);
  assign stat.lo_ok     = (HW'(lo) < stop);
  assign stat.eq        = (rkey == key_r);
  assign stat.idx_ok    = (idx_next < stop);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      step_r <= STEP_W'(1);
      done   <= 1'b0;
    end else begin
      if (step_we) begin
        step_r <= step_data;
      end
      if (cmd.wr) begin
        count <= count + CW'(1);
      end
      done <= cmd.finish;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= item.op;
      key_r <= item.key;
    end
    if (cmd.jump_init) begin
      lo <= '0;
      hi <= hi_init;
    end else if (cmd.jump_adv) begin
      lo <= AW'(hi);
      hi <= hi_adv;
    end
    if (cmd.scan_init) begin
      idx <= lo;
    end else if (cmd.scan_adv) begin
      idx <= AW'(idx_next);
    end
    if (cmd.finish) begin
      result.status <= cmd.fin_status;
      case (cmd.fin_status)
        ST_APPENDED: result.index <= INDEX_W'(count);
        ST_FOUND:    result.index <= INDEX_W'(idx);
        default:     result.index <= '0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/jss_ctrl.sv =====
// Controller state machine: sequences append, jump phase and linear scan.
// Depends on jss_pkg.
module jss_ctrl
  import jss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_JUMP       = 3'd2;
  localparam logic [2:0] S_SCAN_START = 3'd3;
  localparam logic [2:0] S_SCAN       = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_LO;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_search) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
          if (stat.full) begin
            cmd.fin_status = ST_FULL;
          end else begin
            cmd.wr         = 1'b1;
            cmd.fin_status = ST_APPENDED;
          end
        end else begin
          cmd.jump_init = 1'b1;
          cmd.rd_sel    = RD_HI_INIT;
          state_next    = stat.init_ok ? S_JUMP : S_SCAN_START;
        end
      end
      S_JUMP: begin
        // read data is the key at hi
        if (stat.le) begin
          cmd.jump_adv = 1'b1;
          cmd.rd_sel   = RD_HI_ADV;
          state_next   = stat.adv_ok ? S_JUMP : S_SCAN_START;
        end else begin
          state_next = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        cmd.scan_init = 1'b1;
        cmd.rd_sel    = RD_LO;
        if (stat.lo_ok) begin
          state_next = S_SCAN;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_MISSING;
          state_next     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.eq) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FOUND;
          state_next     = S_IDLE;
        end else if (stat.idx_ok) begin
          cmd.scan_adv = 1'b1;
          cmd.rd_sel   = RD_IDX_NEXT;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_MISSING;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for jump_search_sorted_keys: appends, jump searches, step register.
// Depends on jss_pkg and the block's RTL; keeps its own copy of the key table and count.
module tb
  import jss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 750;
  localparam int GROWTH_TARGET = 104;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  in_item_t          req_item;
  logic              step_we;
  logic [STEP_W-1:0] step_data;
  logic              done;
  out_item_t         resp;

  jump_search_sorted_keys #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (req_item),
    .step_we  (step_we),
    .step_data(step_data),
    .done     (done),
    .result   (resp)
  );

  // shadow of the block's state
  logic signed [KEY_W-1:0] shadow_keys [ENTRIES];
  int                      shadow_count;
  logic [STEP_W-1:0]       shadow_step;
  out_item_t               pending_answers [$];

  longint chain_last;    // last key of the ascending chain
  int     sent_items;
  int     directed_items;
  int     fail_count;
  int     step_writes;
  int     n_appended, n_full, n_found, n_missing;
  int     cycle_count;
  out_item_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected answer for one accepted beat; appends update the shadow table.
  function automatic out_item_t lookup_answer(in_item_t it);
    out_item_t ans;
    int        stp, lo, hi, stop, i;
    logic      hit;
    ans = '0;
    if (it.op == OP_APPEND) begin
      if (shadow_count >= ENTRIES) begin
        ans.status = ST_FULL;
      end else begin
        shadow_keys[shadow_count] = it.key;
        ans.status = ST_APPENDED;
        ans.index  = INDEX_W'(shadow_count);
        shadow_count++;
      end
    end else begin
      stp = (shadow_step == 0) ? 1 : int'(shadow_step);
      lo  = 0;
      hi  = stp;
      while (hi < shadow_count && $signed(shadow_keys[hi]) <= $signed(it.key)) begin
        lo = hi;
        hi += stp;
      end
      stop = (hi < shadow_count) ? hi : shadow_count;
      hit  = 1'b0;
      ans.status = ST_MISSING;
      for (i = lo; i < stop && !hit; i++) begin
        if (shadow_keys[i] == it.key) begin
          hit        = 1'b1;
          ans.status = ST_FOUND;
          ans.index  = INDEX_W'(i);
        end
      end
    end
    return ans;
  endfunction

  // Result check first, then prediction for a beat taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          $error("result with nothing pending: status %0d index %0d",
                 resp.status, resp.index);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (resp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, resp.status);
            fail_count++;
          end
          if (resp.index !== want.index) begin
            $error("index mismatch: expected %0d, got %0d", want.index, resp.index);
            fail_count++;
          end
        end
        case (resp.status)
          ST_APPENDED: n_appended++;
          ST_FULL:     n_full++;
          ST_FOUND:    n_found++;
          default:     n_missing++;
        endcase
      end
      if (start && !busy) pending_answers.push_back(lookup_answer(req_item));
    end
  end

  // Runs at a falling edge; returns at the falling edge after acceptance with start still high.
  task automatic send_beat(input logic op_bit, input logic signed [KEY_W-1:0] k);
    int  gap;
    logic quiet;
    quiet = (sent_items >= 200 && sent_items < 360);
    if (!quiet && $urandom_range(0, 99) < 37) begin
      gap   = $urandom_range(1, 8);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_item.op  = op_bit;
    req_item.key = k;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_answers.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_step(input logic [STEP_W-1:0] v);
    wait_idle();
    step_we   = 1'b1;
    step_data = v;
    @(negedge clk);
    step_we     = 1'b0;
    shadow_step = v;
    step_writes++;
  endtask

  // Next key of the ascending chain; the last free slot always gets KEY_MAX.
  function automatic logic signed [KEY_W-1:0] next_sorted_key();
    longint room, gap_max, gap;
    int     slots_left;
    slots_left = ENTRIES - shadow_count;
    if (slots_left <= 1) begin
      chain_last = longint'(KEY_MAX);
    end else begin
      room    = longint'(KEY_MAX) - chain_last;
      gap_max = (room * 2) / slots_left;
      if (gap_max > room) gap_max = room;
      if (gap_max < 1) gap_max = 1;
      if (chain_last >= longint'(KEY_MIN) && $urandom_range(0, 9) == 0)
        gap = 0;  // duplicate key
      else
        gap = longint'($urandom_range(1, 32'(gap_max)));
      chain_last += gap;
    end
    return KEY_W'(chain_last);
  endfunction

  function automatic logic [STEP_W-1:0] choose_step();
    int r, s;
    r = $urandom_range(0, 99);
    s = 1;
    while ((s + 1) * (s + 1) <= shadow_count) s++;
    if (r < 50) return STEP_W'(s);
    if (r < 60) return '0;
    if (r < 70) return 8'd1;
    if (r < 80) return 8'd255;
    if (r < 85) return 8'd128;
    return STEP_W'($urandom_range(1, 255));
  endfunction

  // Mostly searches for stored keys and their neighbours, some appends and noise.
  task automatic random_beat(input logic sorted_appends);
    int r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (shadow_count > 0)
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    else
      k = $urandom;
    if (r < 8) begin
      if (sorted_appends && shadow_count < ENTRIES - 8)
        send_beat(OP_APPEND, next_sorted_key());
      else
        send_beat(OP_APPEND, KEY_W'($urandom));
    end else if (r < 55) begin
      send_beat(OP_SEARCH, k);
    end else if (r < 75) begin
      send_beat(OP_SEARCH, ($urandom_range(0, 1) != 0) ? k + 1 : k - 1);
    end else if (r < 85) begin
      send_beat(OP_SEARCH, ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX);
    end else begin
      send_beat(OP_SEARCH, KEY_W'($urandom));
    end
  endtask

  task automatic test_empty_table();
    set_step('0);
    send_beat(OP_SEARCH, KEY_MIN);
    send_beat(OP_SEARCH, KEY_MAX);
    send_beat(OP_SEARCH, 32'sd0);
  endtask

  task automatic test_directed_keys();
    send_beat(OP_APPEND, KEY_MIN);
    send_beat(OP_APPEND, -32'sd5);
    send_beat(OP_APPEND, -32'sd5);
    send_beat(OP_APPEND, 32'sd7);
    send_beat(OP_APPEND, 32'sd100);
    chain_last = 100;
    send_beat(OP_SEARCH, -32'sd5);    // duplicate key
    send_beat(OP_SEARCH, KEY_MIN);
    send_beat(OP_SEARCH, 32'sd100);
    send_beat(OP_SEARCH, 32'sd6);
    send_beat(OP_SEARCH, KEY_MAX);
    set_step(8'd255);                 // step past the count: plain scan
    send_beat(OP_SEARCH, 32'sd100);
    send_beat(OP_SEARCH, 32'sd7);
    send_beat(OP_SEARCH, 32'sd8);
    set_step(8'd2);
    send_beat(OP_SEARCH, 32'sd7);
    send_beat(OP_SEARCH, -32'sd5);
    send_beat(OP_SEARCH, KEY_MIN);
    directed_items = sent_items;
  endtask

  task automatic test_sorted_growth();
    int burst, mix;
    while (shadow_count < GROWTH_TARGET) begin
      burst = $urandom_range(2, 12);
      repeat (burst) begin
        if (shadow_count < GROWTH_TARGET) send_beat(OP_APPEND, next_sorted_key());
      end
      set_step(choose_step());
      mix = $urandom_range(15, 35);
      repeat (mix) random_beat(1'b1);
    end
  endtask

  // Out-of-order keys: a search may miss a key that is present.
  task automatic test_unsorted_keys();
    int n;
    set_step(choose_step());
    repeat (6) begin
      send_beat(OP_APPEND, KEY_W'($urandom));
      n = $urandom_range(2, 6);
      repeat (n) random_beat(1'b0);
    end
  endtask

  task automatic test_table_full();
    logic [STEP_W-1:0] steps [6];
    int i;
    steps = '{8'd1, 8'd11, 8'd127, 8'd128, 8'd255, 8'd0};
    while (shadow_count < ENTRIES) begin
      send_beat(OP_APPEND, next_sorted_key());
      if ($urandom_range(0, 2) == 0) random_beat(1'b0);
    end
    send_beat(OP_APPEND, KEY_MAX);    // dropped
    send_beat(OP_SEARCH, KEY_MAX);    // last slot
    i = 0;
    while (sent_items < directed_items + RANDOM_ITEMS) begin
      set_step((i < 6) ? steps[i] : choose_step());
      send_beat(OP_SEARCH, KEY_MAX);
      repeat ($urandom_range(20, 40)) random_beat(1'b0);
      i++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req_item     = '0;
    step_we      = 1'b0;
    step_data    = '0;
    shadow_count = 0;
    shadow_step  = 8'd1;
    chain_last   = longint'(KEY_MIN) - 1;
    sent_items   = 0;
    fail_count   = 0;
    step_writes  = 0;
    n_appended   = 0;
    n_full       = 0;
    n_found      = 0;
    n_missing    = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_directed_keys();
    test_sorted_growth();
    test_unsorted_keys();
    test_table_full();

    wait_idle();
    repeat (16) @(negedge clk);
    $display("Run covered %0d beats: %0d appended, %0d dropped full, %0d found, %0d missing.",
             sent_items, n_appended, n_full, n_found, n_missing);
    $display("Step register written %0d times; %0d mismatches.", step_writes, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycle_count, pending_answers.size());
    $display("FAILURE");
    $finish;
  end

endmodule
